// File: rtl/vidhc_pkg.sv
// Package for the video identification header checker.
// Holds the beat types, the packet summary type, the status codes and fixed constants.
// No dependencies.
package vidhc_pkg;

  // Byte counter limits. The counter saturates at its top value.
  localparam logic [5:0] COUNT_MAX  = 6'd63;
  localparam logic [5:0] MIN_LENGTH = 6'd7;
  localparam logic [5:0] ID_LENGTH  = 6'd42;

  // Byte values checked in the version bytes.
  localparam logic [7:0] VERSION_MAJOR = 8'd3;
  localparam logic [7:0] VERSION_MINOR = 8'd2;

  // Macroblocks are 16 pixels on a side.
  localparam int MB_SHIFT = 4;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ID_OK     = 3'd0,
    ST_OTHER_OK  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_NOT_HDR   = 3'd3,
    ST_BAD_SIG   = 3'd4,
    ST_ID_BAD    = 3'd5
  } status_t;

  // One input beat: a packet byte and its end-of-packet flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    status_t     status;
    logic [6:0]  header_kind;
    logic [15:0] frame_mb_width;
    logic [15:0] frame_mb_height;
    logic [23:0] picture_width;
    logic [23:0] picture_height;
    logic [7:0]  picture_x;
    logic [7:0]  picture_y;
    logic [31:0] rate_numerator;
    logic [31:0] rate_denominator;
    logic [4:0]  keyframe_shift;
    logic [4:0]  quality_hint;
  } out_beat_t;

  // Everything captured from one packet, handed from capture to check.
  typedef struct packed {
    logic        len_short;
    logic        len_exact;
    logic [7:0]  first_byte;
    logic        signature_ok;
    logic        version_ok;
    logic [15:0] mb_width;
    logic [15:0] mb_height;
    logic [23:0] pic_width;
    logic [23:0] pic_height;
    logic [15:0] offsets;
    logic [31:0] rate_num;
    logic [31:0] rate_den;
    logic [15:0] tail_bytes;
  } pkt_sum_t;

  // Expected signature character at byte positions 1 to 6 ("theora").
  function automatic logic [7:0] sig_char(input logic [5:0] pos);
    logic [7:0] c;
    case (pos)
      6'd1:    c = 8'h74;
      6'd2:    c = 8'h68;
      6'd3:    c = 8'h65;
      6'd4:    c = 8'h6F;
      6'd5:    c = 8'h72;
      6'd6:    c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/vidhc_capture.sv
// Byte capture stage of the video identification header checker.
// Counts bytes, captures fixed-offset fields and hands a packet summary downstream.
// Depends on vidhc_pkg.
module vidhc_capture
  import vidhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_ready,
  input  in_beat_t byte_beat,
  output logic     sum_valid,
  input  logic     sum_ready,
  output pkt_sum_t sum
);

  logic [5:0]  byte_count, byte_count_next;
  logic [7:0]  first_byte, first_byte_next;
  logic        signature_ok, signature_ok_next;
  logic        version_ok, version_ok_next;
  logic [15:0] mb_width, mb_width_next;
  logic [15:0] mb_height, mb_height_next;
  logic [23:0] pic_width, pic_width_next;
  logic [23:0] pic_height, pic_height_next;
  logic [15:0] offsets, offsets_next;
  logic [31:0] rate_num, rate_num_next;
  logic [31:0] rate_den, rate_den_next;
  logic [15:0] tail_bytes, tail_bytes_next;
  logic [7:0]  b;
  logic        take;

  assign b          = byte_beat.data_byte;
  assign byte_ready = !sum_valid || sum_ready;
  assign take       = byte_valid && byte_ready;

  // Field capture by byte position; big-endian fields shift in one byte at a time.
  always_comb begin
    byte_count_next   = (byte_count == COUNT_MAX) ? byte_count : byte_count + 6'd1;
    first_byte_next   = first_byte;
    signature_ok_next = signature_ok;
    version_ok_next   = version_ok;
    mb_width_next     = mb_width;
    mb_height_next    = mb_height;
    pic_width_next    = pic_width;
    pic_height_next   = pic_height;
    offsets_next      = offsets;
    rate_num_next     = rate_num;
    rate_den_next     = rate_den;
    tail_bytes_next   = tail_bytes;
    if (byte_count == 6'd0) begin
      first_byte_next = b;
    end else if (byte_count <= 6'd6) begin
      if (b != sig_char(byte_count)) signature_ok_next = 1'b0;
    end else if (byte_count == 6'd7) begin
      if (b != VERSION_MAJOR) version_ok_next = 1'b0;
    end else if (byte_count == 6'd8) begin
      if (b != VERSION_MINOR) version_ok_next = 1'b0;
    end else if (byte_count == 6'd9) begin
      // The revision byte is not checked.
    end else if (byte_count <= 6'd11) begin
      mb_width_next = {mb_width[7:0], b};
    end else if (byte_count <= 6'd13) begin
      mb_height_next = {mb_height[7:0], b};
    end else if (byte_count <= 6'd16) begin
      pic_width_next = {pic_width[15:0], b};
    end else if (byte_count <= 6'd19) begin
      pic_height_next = {pic_height[15:0], b};
    end else if (byte_count <= 6'd21) begin
      offsets_next = {offsets[7:0], b};
    end else if (byte_count <= 6'd25) begin
      rate_num_next = {rate_num[23:0], b};
    end else if (byte_count <= 6'd29) begin
      rate_den_next = {rate_den[23:0], b};
    end else if (byte_count >= 6'd40 && byte_count <= 6'd41) begin
      tail_bytes_next = {tail_bytes[7:0], b};
    end
  end

  // Accumulator registers; they return to reset values after the last byte.
  always_ff @(posedge clk) begin
    if (rst || (take && byte_beat.last_byte)) begin
      byte_count   <= '0;
      first_byte   <= '0;
      signature_ok <= 1'b1;
      version_ok   <= 1'b1;
      mb_width     <= '0;
      mb_height    <= '0;
      pic_width    <= '0;
      pic_height   <= '0;
      offsets      <= '0;
      rate_num     <= '0;
      rate_den     <= '0;
      tail_bytes   <= '0;
    end else if (take) begin
      byte_count   <= byte_count_next;
      first_byte   <= first_byte_next;
      signature_ok <= signature_ok_next;
      version_ok   <= version_ok_next;
      mb_width     <= mb_width_next;
      mb_height    <= mb_height_next;
      pic_width    <= pic_width_next;
      pic_height   <= pic_height_next;
      offsets      <= offsets_next;
      rate_num     <= rate_num_next;
      rate_den     <= rate_den_next;
      tail_bytes   <= tail_bytes_next;
    end
  end

  // Summary register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (take && byte_beat.last_byte) begin
      sum_valid <= 1'b1;
    end else if (sum_ready) begin
      sum_valid <= 1'b0;
    end
  end

  // Summary payload, loaded from the values that include the last byte.
  always_ff @(posedge clk) begin
    if (take && byte_beat.last_byte) begin
      sum.len_short    <= byte_count_next < MIN_LENGTH;
      sum.len_exact    <= byte_count_next == ID_LENGTH;
      sum.first_byte   <= first_byte_next;
      sum.signature_ok <= signature_ok_next;
      sum.version_ok   <= version_ok_next;
      sum.mb_width     <= mb_width_next;
      sum.mb_height    <= mb_height_next;
      sum.pic_width    <= pic_width_next;
      sum.pic_height   <= pic_height_next;
      sum.offsets      <= offsets_next;
      sum.rate_num     <= rate_num_next;
      sum.rate_den     <= rate_den_next;
      sum.tail_bytes   <= tail_bytes_next;
    end
  end

endmodule

// File: rtl/vidhc_check.sv
// Check stage of the video identification header checker.
// Classifies a packet summary, validates the identification fields, registers the result.
// Depends on vidhc_pkg.
module vidhc_check
  import vidhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      sum_valid,
  output logic      sum_ready,
  input  pkt_sum_t  sum,
  output logic      result_valid,
  input  logic      result_ready,
  output out_beat_t result
);

  out_beat_t   beat_next;
  status_t     status_next;
  logic [6:0]  kind;
  logic [23:0] wpix, hpix;
  logic [23:0] px, py;
  logic        id_ok;

  assign sum_ready = !result_valid || result_ready;
  assign kind      = sum.first_byte[6:0];

  // Picture region must fit inside the macroblock-aligned frame.
  always_comb begin
    wpix  = {4'd0, sum.mb_width, {MB_SHIFT{1'b0}}};
    hpix  = {4'd0, sum.mb_height, {MB_SHIFT{1'b0}}};
    px    = {16'd0, sum.offsets[15:8]};
    py    = {16'd0, sum.offsets[7:0]};
    id_ok = sum.len_exact && sum.version_ok &&
            (sum.mb_width != '0) && (sum.mb_height != '0) &&
            (sum.pic_width <= wpix) && (sum.pic_height <= hpix) &&
            (px <= wpix - sum.pic_width) && (py <= hpix - sum.pic_height) &&
            (sum.rate_num != '0) && (sum.rate_den != '0);
  end

  // Status in priority order, then the decoded fields for identification headers.
  always_comb begin
    if (sum.len_short) begin
      status_next = ST_SHORT;
    end else if (!sum.first_byte[7]) begin
      status_next = ST_NOT_HDR;
    end else if (!sum.signature_ok) begin
      status_next = ST_BAD_SIG;
    end else if (kind != 7'd0) begin
      status_next = ST_OTHER_OK;
    end else if (id_ok) begin
      status_next = ST_ID_OK;
    end else begin
      status_next = ST_ID_BAD;
    end
    beat_next             = '0;
    beat_next.status      = status_next;
    beat_next.header_kind = kind;
    if (status_next == ST_ID_OK || status_next == ST_ID_BAD) begin
      beat_next.frame_mb_width   = sum.mb_width;
      beat_next.frame_mb_height  = sum.mb_height;
      beat_next.picture_width    = sum.pic_width;
      beat_next.picture_height   = sum.pic_height;
      beat_next.picture_x        = sum.offsets[15:8];
      beat_next.picture_y        = sum.offsets[7:0];
      beat_next.rate_numerator   = sum.rate_num;
      beat_next.rate_denominator = sum.rate_den;
      beat_next.keyframe_shift   = sum.tail_bytes[9:5];
      beat_next.quality_hint     = sum.tail_bytes[15:11];
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (sum_ready) begin
      result_valid <= sum_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      result <= beat_next;
    end
  end

endmodule

// File: rtl/video_id_header_checker.sv
// Top level of the video identification header checker.
// Instantiates the capture and check stages; depends on vidhc_pkg.
//
// Usage:
//   The byte channel (byte_valid, byte_ready, byte_beat) takes one packet byte
//   per beat; last_byte marks the final byte of a header packet. Every byte
//   but the last produces nothing. The last byte produces one beat on the
//   result channel (result_valid, result_ready, result_beat) holding the
//   status and, for identification headers, the decoded fields.
//   Throughput is one byte per cycle while the result side takes beats.
//   A result passes the capture summary register, then the result register.
//   Both stages hold one packet each, so with a stalled receiver the block
//   still takes every byte of the next packet up to and including its last
//   byte, and only then holds byte_ready low until a result is taken.
//   Reset clears the byte counter, the captured fields and both valid flags;
//   the block then waits for the first byte of a packet.
module video_id_header_checker
  import vidhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_beat_t  byte_beat,
  output logic      result_valid,
  input  logic      result_ready,
  output out_beat_t result_beat
);

  logic     sum_valid;
  logic     sum_ready;
  pkt_sum_t sum;

  vidhc_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_beat  (byte_beat),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (sum)
  );

  vidhc_check u_check (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .sum          (sum),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat)
  );

  // A last byte always lands in the summary register.
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && byte_beat.last_byte |=> sum_valid)
    else $error("last byte did not reach the summary register");

  // A valid identification header has kind zero and nonzero macroblock sizes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_beat.status == ST_ID_OK |->
      result_beat.header_kind == 7'd0 && result_beat.frame_mb_width != 16'd0 &&
      result_beat.frame_mb_height != 16'd0)
    else $error("identification header passed with bad fields");

  // Non-identification statuses carry zero fields.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_beat.status == ST_OTHER_OK ||
      result_beat.status == ST_SHORT || result_beat.status == ST_NOT_HDR ||
      result_beat.status == ST_BAD_SIG) |->
      result_beat.frame_mb_width == 16'd0 && result_beat.rate_numerator == 32'd0 &&
      result_beat.picture_width == 24'd0)
    else $error("fields not cleared for a non-identification status");

endmodule

// File: tb/sv/video_id_header_checker_tb.sv
// Testbench for video_id_header_checker: directed and random header packets
// with random idling on both channels, checked against a built-in predictor.
// Depends on vidhc_pkg and the checker RTL.
`timescale 1ns / 100ps

module video_id_header_checker_tb
  import vidhc_pkg::*;
();

  // First byte of the three header packet types.
  localparam logic [7:0] HDR_ID      = 8'h80;
  localparam logic [7:0] HDR_COMMENT = 8'h81;
  localparam logic [7:0] HDR_SETUP   = 8'h82;
  // Signature text carried in bytes 1 to 6, first character in the top byte.
  localparam logic [47:0] SIGNATURE = "theora";
  localparam int RANDOM_BYTES = 2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_beat_t  byte_beat = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_beat_t result_beat;

  // Decodes the header bytes as they are accepted and holds the results due.
  class header_tracker;
    out_beat_t   due_results[$];
    int          errors;
    int unsigned count;
    logic [7:0]  first;
    bit          sig_ok;
    bit          ver_ok;
    logic [15:0] mb_w;
    logic [15:0] mb_h;
    logic [23:0] pic_w;
    logic [23:0] pic_h;
    logic [15:0] offsets;
    logic [31:0] rate_num;
    logic [31:0] rate_den;
    logic [15:0] tail;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      count = 0;
      first = '0;
      sig_ok = 1'b1;
      ver_ok = 1'b1;
      mb_w = '0;
      mb_h = '0;
      pic_w = '0;
      pic_h = '0;
      offsets = '0;
      rate_num = '0;
      rate_den = '0;
      tail = '0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Captures one accepted byte; the last byte of a packet yields a result.
    function void take_byte(in_beat_t beat);
      int unsigned pos;
      logic [7:0]  b;
      pos = count;
      b = beat.data_byte;
      if (pos == 0) begin
        first = b;
      end else if (pos <= 6) begin
        if (b != SIGNATURE[8*(6-pos) +: 8]) sig_ok = 1'b0;
      end else if (pos == 7) begin
        if (b != VERSION_MAJOR) ver_ok = 1'b0;
      end else if (pos == 8) begin
        if (b != VERSION_MINOR) ver_ok = 1'b0;
      end else if (pos == 9) begin
        // The revision byte is not checked.
      end else if (pos <= 11) begin
        mb_w = {mb_w[7:0], b};
      end else if (pos <= 13) begin
        mb_h = {mb_h[7:0], b};
      end else if (pos <= 16) begin
        pic_w = {pic_w[15:0], b};
      end else if (pos <= 19) begin
        pic_h = {pic_h[15:0], b};
      end else if (pos <= 21) begin
        offsets = {offsets[7:0], b};
      end else if (pos <= 25) begin
        rate_num = {rate_num[23:0], b};
      end else if (pos <= 29) begin
        rate_den = {rate_den[23:0], b};
      end else if (pos >= 40 && pos <= 41) begin
        tail = {tail[7:0], b};
      end
      if (count < COUNT_MAX) count++;
      if (beat.last_byte) begin
        due_results.push_back(decode_packet());
        clear();
      end
    endfunction

    // Status and fields of the packet held so far.
    function out_beat_t decode_packet();
      out_beat_t         r;
      longint unsigned   span_w;
      longint unsigned   span_h;
      bit                ok;
      r = '0;
      r.header_kind = first[6:0];
      if (count < MIN_LENGTH) begin
        r.status = ST_SHORT;
      end else if (!first[7]) begin
        r.status = ST_NOT_HDR;
      end else if (!sig_ok) begin
        r.status = ST_BAD_SIG;
      end else if (first[6:0] != 7'd0) begin
        r.status = ST_OTHER_OK;
      end else begin
        span_w = mb_w;
        span_w = span_w * 16;
        span_h = mb_h;
        span_h = span_h * 16;
        ok = (count == ID_LENGTH) && ver_ok && (mb_w != 0) && (mb_h != 0);
        if (ok && pic_w > span_w) ok = 1'b0;
        if (ok && pic_h > span_h) ok = 1'b0;
        if (ok && offsets[15:8] > span_w - pic_w) ok = 1'b0;
        if (ok && offsets[7:0] > span_h - pic_h) ok = 1'b0;
        if (ok && (rate_num == 0 || rate_den == 0)) ok = 1'b0;
        if (ok) r.status = ST_ID_OK;
        else r.status = ST_ID_BAD;
        r.frame_mb_width = mb_w;
        r.frame_mb_height = mb_h;
        r.picture_width = pic_w;
        r.picture_height = pic_h;
        r.picture_x = offsets[15:8];
        r.picture_y = offsets[7:0];
        r.rate_numerator = rate_num;
        r.rate_denominator = rate_den;
        r.keyframe_shift = tail[9:5];
        r.quality_hint = tail[15:11];
      end
      return r;
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result beat with the oldest one due.
    function void check_result(out_beat_t got);
      out_beat_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("header_kind", want.header_kind, got.header_kind);
      check_field("frame_mb_width", want.frame_mb_width, got.frame_mb_width);
      check_field("frame_mb_height", want.frame_mb_height, got.frame_mb_height);
      check_field("picture_width", want.picture_width, got.picture_width);
      check_field("picture_height", want.picture_height, got.picture_height);
      check_field("picture_x", want.picture_x, got.picture_x);
      check_field("picture_y", want.picture_y, got.picture_y);
      check_field("rate_numerator", want.rate_numerator, got.rate_numerator);
      check_field("rate_denominator", want.rate_denominator, got.rate_denominator);
      check_field("keyframe_shift", want.keyframe_shift, got.keyframe_shift);
      check_field("quality_hint", want.quality_hint, got.quality_hint);
    endfunction
  endclass

  header_tracker sb = new();

  logic [7:0] pkt[$];
  int         sent_bytes = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         stall_left = 0;

  video_id_header_checker dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_beat  (result_beat)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      result_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Every accepted beat on either channel goes to the tracker.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) sb.take_byte(byte_beat);
      if (result_valid && result_ready) sb.check_result(result_beat);
    end
  end

  // Run limit.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Sends one byte, with an occasional idle burst before it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!byte_ready);
    sent_bytes++;
  endtask

  task automatic send_pkt();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Holds the sender back until every result due has arrived. The first
  // edge lets the tracker take the last byte sent before the count is read.
  task automatic drain_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Builds an identification header of the given length into pkt.
  task automatic build_id(input logic [15:0] mb_w, input logic [15:0] mb_h,
                          input logic [23:0] pic_w, input logic [23:0] pic_h,
                          input logic [7:0] px, input logic [7:0] py,
                          input logic [31:0] num, input logic [31:0] den,
                          input logic [15:0] tail, input int len);
    logic [7:0] full[$];
    full.push_back(HDR_ID);
    for (int i = 1; i <= 6; i++) full.push_back(SIGNATURE[8*(6-i) +: 8]);
    full.push_back(VERSION_MAJOR);
    full.push_back(VERSION_MINOR);
    full.push_back(8'($urandom));
    full.push_back(mb_w[15:8]);
    full.push_back(mb_w[7:0]);
    full.push_back(mb_h[15:8]);
    full.push_back(mb_h[7:0]);
    full.push_back(pic_w[23:16]);
    full.push_back(pic_w[15:8]);
    full.push_back(pic_w[7:0]);
    full.push_back(pic_h[23:16]);
    full.push_back(pic_h[15:8]);
    full.push_back(pic_h[7:0]);
    full.push_back(px);
    full.push_back(py);
    for (int i = 3; i >= 0; i--) full.push_back(num[8*i +: 8]);
    for (int i = 3; i >= 0; i--) full.push_back(den[8*i +: 8]);
    for (int i = 30; i < 40; i++) full.push_back(8'($urandom));
    full.push_back(tail[15:8]);
    full.push_back(tail[7:0]);
    pkt = {};
    for (int i = 0; i < len; i++) begin
      if (i < full.size()) pkt.push_back(full[i]);
      else pkt.push_back(8'($urandom));
    end
  endtask

  // Macroblock count: mostly small, sometimes zero or at the extremes.
  function automatic logic [15:0] pick_mb();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // Picture size: mostly within the macroblock span, sometimes just beyond it.
  function automatic logic [23:0] pick_pic(input logic [15:0] mb);
    longint unsigned span;
    span = mb;
    span = span * 16;
    case ($urandom_range(0, 9))
      0:       return 24'(span + $urandom_range(1, 4));
      1:       return 24'(span);
      2:       return 24'($urandom);
      default: return 24'($urandom_range(0, 32'(span)));
    endcase
  endfunction

  // Picture offset: mostly fitting the room left, sometimes one past it.
  function automatic logic [7:0] pick_off(input logic [15:0] mb, input logic [23:0] pic);
    longint unsigned span;
    longint unsigned room;
    span = mb;
    span = span * 16;
    if (pic > span) return 8'($urandom);
    room = span - pic;
    if (room > 255) room = 255;
    case ($urandom_range(0, 7))
      0:       return (room < 255) ? 8'(room + 1) : 8'hFF;
      1:       return 8'(room);
      2:       return 8'($urandom);
      default: return 8'($urandom_range(0, 32'(room)));
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 15))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random identification header with occasional version damage.
  task automatic rand_id(input int len);
    logic [15:0] mb_w;
    logic [15:0] mb_h;
    logic [23:0] pic_w;
    logic [23:0] pic_h;
    mb_w = pick_mb();
    mb_h = pick_mb();
    pic_w = pick_pic(mb_w);
    pic_h = pick_pic(mb_h);
    build_id(mb_w, mb_h, pic_w, pic_h, pick_off(mb_w, pic_w), pick_off(mb_h, pic_h),
             pick_rate(), pick_rate(), 16'($urandom), len);
    if (len > 8 && $urandom_range(0, 19) == 0) pkt[$urandom_range(7, 8)] = 8'($urandom);
  endtask

  initial begin
    int len;
    int kind;
    bit mid_drained;
    mid_drained = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 20;
    stall_pct <= 20;

    // Directed: valid header, then the extremes of every field.
    build_id(16'd20, 16'd15, 24'd320, 24'd240, 8'd0, 8'd0, 32'd30, 32'd1, 16'h1234, 42);
    send_pkt();
    build_id(16'hFFFF, 16'hFFFF, 24'h0FFFF0, 24'h0FFFF0, 8'd0, 8'd0,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 42);
    send_pkt();
    build_id(16'd0, 16'd0, 24'd0, 24'd0, 8'd0, 8'd0, 32'd0, 32'd0, 16'd0, 42);
    send_pkt();
    // Offsets that exactly fill the span, then one past it.
    build_id(16'd1, 16'd1, 24'd0, 24'd0, 8'd16, 8'd16, 32'd1, 32'd1, 16'h0000, 42);
    send_pkt();
    build_id(16'd2, 16'd2, 24'd20, 24'd20, 8'd13, 8'd12, 32'd1, 32'd1, 16'h00E0, 42);
    send_pkt();
    // Picture wider than the macroblock span.
    build_id(16'd4, 16'd4, 24'd65, 24'd64, 8'd0, 8'd0, 32'd25, 32'd1, 16'hF800, 42);
    send_pkt();
    // Zero frame-rate terms.
    build_id(16'd8, 16'd8, 24'd128, 24'd128, 8'd0, 8'd0, 32'd0, 32'd1, 16'h0000, 42);
    send_pkt();
    build_id(16'd8, 16'd8, 24'd128, 24'd128, 8'd0, 8'd0, 32'd1, 32'd0, 16'h0000, 42);
    send_pkt();
    // Wrong version byte.
    build_id(16'd8, 16'd8, 24'd128, 24'd128, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 42);
    pkt[7] = 8'd4;
    send_pkt();
    // Lengths one short, one long, and past the counter's saturation.
    build_id(16'd8, 16'd8, 24'd128, 24'd128, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 41);
    send_pkt();
    build_id(16'd8, 16'd8, 24'd128, 24'd128, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 43);
    send_pkt();
    build_id(16'd8, 16'd8, 24'd128, 24'd128, 8'd0, 8'd0, 32'd1, 32'd1, 16'hFFFF, 70);
    send_pkt();
    // Single byte packet, then a six byte packet, both short.
    pkt = '{HDR_ID};
    send_pkt();
    build_id(16'd1, 16'd1, 24'd0, 24'd0, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 6);
    send_pkt();
    // Short takes precedence over a clear bit 7.
    pkt = '{8'h00, 8'h74, 8'h68};
    send_pkt();
    // Not a header, bad signature, and the other header types.
    build_id(16'd1, 16'd1, 24'd0, 24'd0, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 42);
    pkt[0] = 8'h00;
    send_pkt();
    build_id(16'd1, 16'd1, 24'd0, 24'd0, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 42);
    pkt[6] = 8'h62;
    send_pkt();
    build_id(16'd1, 16'd1, 24'd0, 24'd0, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 42);
    pkt[0] = HDR_COMMENT;
    send_pkt();
    build_id(16'd1, 16'd1, 24'd0, 24'd0, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 9);
    pkt[0] = HDR_SETUP;
    send_pkt();
    build_id(16'd1, 16'd1, 24'd0, 24'd0, 8'd0, 8'd0, 32'd1, 32'd1, 16'h0000, 7);
    pkt[0] = 8'hFF;
    send_pkt();
    drain_results();

    // Random packets, mostly well-formed identification headers.
    while (sent_bytes < RANDOM_BYTES) begin
      if (sent_bytes > RANDOM_BYTES - 400) begin
        idle_pct = 0;
        stall_pct <= 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 30;
        endcase
        stall_pct <= $urandom_range(0, 2) * 15;
      end
      if (!mid_drained && sent_bytes > RANDOM_BYTES / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : int'(ID_LENGTH);
        rand_id(len);
      end else if (kind < 72) begin
        rand_id($urandom_range(7, 70));
        pkt[0] = HDR_ID | 8'($urandom_range(1, 127));
      end else if (kind < 80) begin
        rand_id($urandom_range(7, 50));
        pkt[$urandom_range(1, 6)] ^= 8'($urandom_range(1, 255));
      end else if (kind < 88) begin
        rand_id($urandom_range(1, 50));
        pkt[0][7] = 1'b0;
      end else begin
        len = $urandom_range(1, 70);
        pkt = {};
        repeat (len) pkt.push_back(8'($urandom));
      end
      send_pkt();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/vidhc_pkg.sv
rtl/vidhc_capture.sv
rtl/vidhc_check.sv
rtl/video_id_header_checker.sv
tb/sv/video_id_header_checker_tb.sv
